// ----- rtl/assert_macros.svh -----
// Assertion macros used by the port-level checker of the project.
// No dependencies; each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, off while reset is low.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Check a property on the rising clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ----- rtl/tgcr_pkg.sv -----
// Package for the text glyph column renderer: command codes, sequencer
// step codes, default sizes and the 5x8 font ROM. No dependencies.
package tgcr_pkg;

    localparam int unsigned DEF_COLUMNS   = 128;
    localparam int unsigned DEF_LAST_PAGE = 7;
    localparam int unsigned GLYPH_WIDTH   = 5;
    localparam int unsigned FONT_ENTRIES  = 95;

    localparam logic [7:0] CMD_COL_WINDOW  = 8'h21;
    localparam logic [7:0] CMD_PAGE_WINDOW = 8'h22;
    localparam logic [7:0] CODE_NEWLINE    = 8'h0A;
    localparam logic [7:0] CODE_FIRST      = 8'h20;
    localparam logic [7:0] CODE_LAST       = 8'h7E;
    localparam logic [7:0] BLANK_COLUMN    = 8'h00;

    typedef logic [3:0] step_t;
    typedef logic [6:0] glyph_idx_t;
    typedef logic [2:0] glyph_col_t;

    localparam step_t STEP_COL_CMD   = 4'd0;
    localparam step_t STEP_COL_START = 4'd1;
    localparam step_t STEP_COL_END   = 4'd2;
    localparam step_t STEP_PAGE_CMD  = 4'd3;
    localparam step_t STEP_PAGE_ROW  = 4'd4;
    localparam step_t STEP_PAGE_END  = 4'd5;
    localparam step_t STEP_GLYPH0    = 4'd6;
    localparam step_t STEP_BLANK     = 4'd11;

    typedef logic [7:0] glyph_row_t [GLYPH_WIDTH];

    localparam glyph_row_t GLYPH_ROM [FONT_ENTRIES] = '{
        '{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h2f,8'h00,8'h00},
        '{8'h00,8'h07,8'h00,8'h07,8'h00}, '{8'h14,8'h7f,8'h14,8'h7f,8'h14},
        '{8'h24,8'h2a,8'h7f,8'h2a,8'h12}, '{8'h23,8'h13,8'h08,8'h64,8'h62},
        '{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h03,8'h00,8'h00},
        '{8'h00,8'h1c,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1c,8'h00},
        '{8'h14,8'h08,8'h3E,8'h08,8'h14}, '{8'h08,8'h08,8'h3E,8'h08,8'h08},
        '{8'h00,8'h00,8'hA0,8'h60,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
        '{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
        '{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h42,8'h7F,8'h40,8'h00},
        '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4B,8'h31},
        '{8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
        '{8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
        '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
        '{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00},
        '{8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
        '{8'h00,8'h41,8'h22,8'h14,8'h08}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
        '{8'h32,8'h49,8'h59,8'h51,8'h3E}, '{8'h7C,8'h12,8'h11,8'h12,8'h7C},
        '{8'h7F,8'h49,8'h49,8'h49,8'h36}, '{8'h3E,8'h41,8'h41,8'h41,8'h22},
        '{8'h7F,8'h41,8'h41,8'h22,8'h1C}, '{8'h7F,8'h49,8'h49,8'h49,8'h41},
        '{8'h7F,8'h09,8'h09,8'h09,8'h01}, '{8'h3E,8'h41,8'h49,8'h49,8'h7A},
        '{8'h7F,8'h08,8'h08,8'h08,8'h7F}, '{8'h00,8'h41,8'h7F,8'h41,8'h00},
        '{8'h20,8'h40,8'h41,8'h3F,8'h01}, '{8'h7F,8'h08,8'h14,8'h22,8'h41},
        '{8'h7F,8'h40,8'h40,8'h40,8'h40}, '{8'h7F,8'h02,8'h0C,8'h02,8'h7F},
        '{8'h7F,8'h04,8'h08,8'h10,8'h7F}, '{8'h3E,8'h41,8'h41,8'h41,8'h3E},
        '{8'h7F,8'h09,8'h09,8'h09,8'h06}, '{8'h3E,8'h41,8'h51,8'h21,8'h5E},
        '{8'h7F,8'h09,8'h19,8'h29,8'h46}, '{8'h46,8'h49,8'h49,8'h49,8'h31},
        '{8'h01,8'h01,8'h7F,8'h01,8'h01}, '{8'h3F,8'h40,8'h40,8'h40,8'h3F},
        '{8'h1F,8'h20,8'h40,8'h20,8'h1F}, '{8'h3F,8'h40,8'h38,8'h40,8'h3F},
        '{8'h63,8'h14,8'h08,8'h14,8'h63}, '{8'h07,8'h08,8'h70,8'h08,8'h07},
        '{8'h61,8'h51,8'h49,8'h45,8'h43}, '{8'h00,8'h7F,8'h41,8'h41,8'h00},
        '{8'h55,8'hAA,8'h55,8'hAA,8'h55}, '{8'h00,8'h41,8'h41,8'h7F,8'h00},
        '{8'h04,8'h02,8'h01,8'h02,8'h04}, '{8'h40,8'h40,8'h40,8'h40,8'h40},
        '{8'h00,8'h03,8'h05,8'h00,8'h00}, '{8'h20,8'h54,8'h54,8'h54,8'h78},
        '{8'h7F,8'h48,8'h44,8'h44,8'h38}, '{8'h38,8'h44,8'h44,8'h44,8'h20},
        '{8'h38,8'h44,8'h44,8'h48,8'h7F}, '{8'h38,8'h54,8'h54,8'h54,8'h18},
        '{8'h08,8'h7E,8'h09,8'h01,8'h02}, '{8'h18,8'hA4,8'hA4,8'hA4,8'h7C},
        '{8'h7F,8'h08,8'h04,8'h04,8'h78}, '{8'h00,8'h44,8'h7D,8'h40,8'h00},
        '{8'h40,8'h80,8'h84,8'h7D,8'h00}, '{8'h7F,8'h10,8'h28,8'h44,8'h00},
        '{8'h00,8'h41,8'h7F,8'h40,8'h00}, '{8'h7C,8'h04,8'h18,8'h04,8'h78},
        '{8'h7C,8'h08,8'h04,8'h04,8'h78}, '{8'h38,8'h44,8'h44,8'h44,8'h38},
        '{8'hFC,8'h24,8'h24,8'h24,8'h18}, '{8'h18,8'h24,8'h24,8'h18,8'hFC},
        '{8'h7C,8'h08,8'h04,8'h04,8'h08}, '{8'h48,8'h54,8'h54,8'h54,8'h20},
        '{8'h04,8'h3F,8'h44,8'h40,8'h20}, '{8'h3C,8'h40,8'h40,8'h20,8'h7C},
        '{8'h1C,8'h20,8'h40,8'h20,8'h1C}, '{8'h3C,8'h40,8'h30,8'h40,8'h3C},
        '{8'h44,8'h28,8'h10,8'h28,8'h44}, '{8'h1C,8'hA0,8'hA0,8'hA0,8'h7C},
        '{8'h44,8'h64,8'h54,8'h4C,8'h44}, '{8'h00,8'h10,8'h7C,8'h82,8'h00},
        '{8'h00,8'h00,8'hFF,8'h00,8'h00}, '{8'h00,8'h82,8'h7C,8'h10,8'h00},
        '{8'h00,8'h06,8'h09,8'h09,8'h06}
    };

    function automatic logic [7:0] glyph_byte(glyph_idx_t idx, glyph_col_t col);
        glyph_row_t row;
        row = GLYPH_ROM[idx];
        return row[col];
    endfunction

endpackage

// ----- rtl/text_glyph_column_renderer.sv -----
// Character-to-display-byte renderer for a page-addressed monochrome OLED:
// each accepted character yields six bytes, one per cycle unless m_ready stalls
// the output (glyph columns plus a blank column, or the six address-window
// commands for a newline), and twelve when the character wraps to the next page
// row. The byte sequencer, which walks one step per cycle from a registered
// request, sets that rate; the next request is taken in the cycle the last byte
// of the current one moves to the output register, so requests run on without a gap.
// Depends on tgcr_pkg.
module text_glyph_column_renderer
    import tgcr_pkg::*;
#(
    parameter int unsigned COLUMNS   = DEF_COLUMNS,
    parameter int unsigned LAST_PAGE = DEF_LAST_PAGE
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_character,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_is_command,
    output logic [7:0] m_out_byte,
    output logic       m_last
);

    logic [2:0] row_reg, row_next;
    logic [7:0] cursor_reg, cursor_next;

    logic       busy_reg;
    step_t      step_reg;
    logic       newline_reg;
    glyph_idx_t idx_reg;
    logic [2:0] req_row_reg;

    logic       m_valid_reg;
    logic       m_is_command_reg;
    logic [7:0] m_out_byte_reg;
    logic       m_last_reg;

    logic       accept;
    logic       advance;
    logic       step_last;
    logic       in_newline;
    logic       in_wrap;
    logic       in_printable;
    glyph_idx_t in_idx;
    logic [7:0] byte_next;

    assign advance   = busy_reg && (!m_valid_reg || m_ready);
    assign step_last = newline_reg ? (step_reg == STEP_PAGE_END) : (step_reg == STEP_BLANK);
    assign s_ready   = !busy_reg || (advance && step_last);
    assign accept    = s_valid && s_ready;

    assign in_newline   = (s_character == CODE_NEWLINE);
    assign in_wrap      = in_newline ||
                          (({1'b0, cursor_reg} + 9'(GLYPH_WIDTH)) >= 9'(COLUMNS));
    assign in_printable = s_character inside {[CODE_FIRST:CODE_LAST]};
    assign in_idx       = in_printable ? 7'(s_character - CODE_FIRST) : '0;

    always_comb begin
        row_next    = row_reg;
        cursor_next = cursor_reg;
        if (in_wrap) begin
            row_next    = (row_reg >= 3'(LAST_PAGE)) ? 3'd0 : row_reg + 3'd1;
            cursor_next = '0;
        end
        if (!in_newline) begin
            cursor_next = cursor_next + 8'(GLYPH_WIDTH + 1);
        end
    end

    always_comb begin
        case (step_reg)
            STEP_COL_CMD:   byte_next = CMD_COL_WINDOW;
            STEP_COL_START: byte_next = 8'd0;
            STEP_COL_END:   byte_next = 8'(COLUMNS - 1);
            STEP_PAGE_CMD:  byte_next = CMD_PAGE_WINDOW;
            STEP_PAGE_ROW:  byte_next = {5'd0, req_row_reg};
            STEP_PAGE_END:  byte_next = 8'(LAST_PAGE);
            STEP_BLANK:     byte_next = BLANK_COLUMN;
            default:        byte_next = glyph_byte(idx_reg, 3'(step_reg - STEP_GLYPH0));
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg     <= '0;
            cursor_reg  <= '0;
            busy_reg    <= 1'b0;
            step_reg    <= STEP_COL_CMD;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                row_reg    <= row_next;
                cursor_reg <= cursor_next;
                busy_reg   <= 1'b1;
                step_reg   <= in_wrap ? STEP_COL_CMD : STEP_GLYPH0;
            end else if (advance) begin
                if (step_last) begin
                    busy_reg <= 1'b0;
                end
                step_reg <= step_reg + 4'd1;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            newline_reg <= in_newline;
            idx_reg     <= in_idx;
            req_row_reg <= row_next;
        end
        if (advance) begin
            m_is_command_reg <= (step_reg < STEP_GLYPH0);
            m_out_byte_reg   <= byte_next;
            m_last_reg       <= step_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_is_command = m_is_command_reg;
    assign m_out_byte   = m_out_byte_reg;
    assign m_last       = m_last_reg;

endmodule

// ----- rtl/tgcr_checker.sv -----
// Port-level checks for text_glyph_column_renderer, bound into the renderer module.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module tgcr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_character,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_is_command,
    input logic [7:0] m_out_byte,
    input logic       m_last
);

    `ASSERT_CLK(a_in_hold, aclk, aresetn, s_valid && !s_ready |=> s_valid && $stable(s_character))

    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_out_byte))

    `ASSERT_CLK(a_out_flags_hold, aclk, aresetn, m_valid && !m_ready |=> $stable({m_is_command, m_last}))

    `ASSERT_CLK(a_data_ends_blank, aclk, aresetn, m_valid && m_last && !m_is_command |-> m_out_byte == 8'h00)

    `ASSERT_CLK_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)

endmodule

bind text_glyph_column_renderer tgcr_checker u_tgcr_checker (.*);

// ----- test/text_glyph_column_renderer_checker.sv -----
`timescale 1ns / 100ps
// Display-byte checker for the text glyph column renderer: predicts the bytes of every
// accepted character request and compares them with the result channel, in order.
// Depends on tgcr_pkg for command and character codes and default sizes.
module text_glyph_column_renderer_checker
    import tgcr_pkg::*;
#(
    parameter int unsigned COLUMNS   = DEF_COLUMNS,
    parameter int unsigned LAST_PAGE = DEF_LAST_PAGE
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_character,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_is_command,
    input  logic [7:0] m_out_byte,
    input  logic       m_last,
    output int         mismatches,
    output int         outstanding,
    output int         bytes_checked,
    output int         row_advances
);

    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic       is_command;
        logic [7:0] data;
        logic       last;
    } display_byte_t;

    // Column 0 of each glyph sits in the top byte.
    localparam logic [39:0] FONT [95] = '{
        40'h0000000000, 40'h00002f0000, 40'h0007000700, 40'h147f147f14, 40'h242a7f2a12,
        40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001c224100, 40'h0041221c00,
        40'h14083E0814, 40'h08083E0808, 40'h0000A06000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
        40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201510906, 40'h324959513E, 40'h7C1211127C, 40'h7F49494936,
        40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
        40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
        40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h55AA55AA55, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0003050000,
        40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
        40'h087E090102, 40'h18A4A4A47C, 40'h7F08040478, 40'h00447D4000, 40'h4080847D00,
        40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'hFC24242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
        40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h1CA0A0A07C,
        40'h4464544C44, 40'h00107C8200, 40'h0000FF0000, 40'h00827C1000, 40'h0006090906
    };

    display_byte_t pending_bytes [$];
    logic [2:0]    page_row;
    logic [7:0]    column_cursor;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("%0t ns: %s: got %02h, expected %02h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic queue_byte(input logic is_command, input logic [7:0] data);
        pending_bytes.push_back('{is_command, data, 1'b0});
    endtask

    task automatic render_character(input logic [7:0] ch);
        logic newline;
        int   idx;
        newline = (ch == CODE_NEWLINE);
        if (newline || column_cursor + GLYPH_WIDTH >= COLUMNS) begin
            page_row      = (page_row >= LAST_PAGE) ? 3'd0 : page_row + 3'd1;
            column_cursor = 8'd0;
            row_advances++;
            queue_byte(1'b1, CMD_COL_WINDOW);
            queue_byte(1'b1, 8'd0);
            queue_byte(1'b1, 8'(COLUMNS - 1));
            queue_byte(1'b1, CMD_PAGE_WINDOW);
            queue_byte(1'b1, {5'd0, page_row});
            queue_byte(1'b1, 8'(LAST_PAGE));
        end
        if (!newline) begin
            idx = (ch inside {[CODE_FIRST:CODE_LAST]}) ? int'(ch - CODE_FIRST) : 0;
            for (int c = 0; c < GLYPH_WIDTH; c++)
                queue_byte(1'b0, FONT[idx][39 - 8 * c -: 8]);
            queue_byte(1'b0, BLANK_COLUMN);
            column_cursor = column_cursor + 8'(GLYPH_WIDTH + 1);
        end
        pending_bytes[pending_bytes.size() - 1].last = 1'b1;
    endtask

    always @(posedge aclk) begin
        display_byte_t want;
        if (!aresetn) begin
            pending_bytes.delete();
            page_row      = 3'd0;
            column_cursor = 8'd0;
            mismatches    = 0;
            bytes_checked = 0;
            row_advances  = 0;
        end else begin
            if (m_valid && m_ready) begin
                bytes_checked++;
                if (pending_bytes.size() == 0) begin
                    report_mismatch("display byte with no character pending", m_out_byte,
                                    8'h00);
                end else begin
                    want = pending_bytes.pop_front();
                    if (m_is_command !== want.is_command)
                        report_mismatch("is_command", {7'd0, m_is_command},
                                        {7'd0, want.is_command});
                    if (m_out_byte !== want.data)
                        report_mismatch("out_byte", m_out_byte, want.data);
                    if (m_last !== want.last)
                        report_mismatch("last", {7'd0, m_last}, {7'd0, want.last});
                end
            end
            if (s_valid && s_ready)
                render_character(s_character);
        end
        outstanding <= pending_bytes.size();
    end

endmodule

// ----- test/tb_text_glyph_column_renderer.sv -----
`timescale 1ns / 100ps
// Testbench top for the text glyph column renderer: drives character requests under
// several idling patterns and gives the verdict. Depends on tgcr_pkg, the renderer
// and text_glyph_column_renderer_checker.
module tb_text_glyph_column_renderer
    import tgcr_pkg::*;
();

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 3000;
    localparam int DRAIN_CYCLES    = 40;

    localparam logic [7:0] DIRECTED [24] = '{
        8'h41, CODE_NEWLINE, CODE_FIRST, CODE_LAST, 8'h7F, 8'h1F, 8'h00, 8'hFF,
        8'h80, 8'h09, 8'h0B, 8'h0D, 8'h21, 8'h30, 8'h5B, 8'h5C,
        8'h61, 8'h7A, 8'h7D, 8'h7C, 8'h2E, 8'h57, 8'h6D, 8'h40
    };

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_character = 8'h00;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic       m_is_command;
    logic [7:0] m_out_byte;
    logic       m_last;

    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int          hold_offs_asked    = 0;
    int          hold_offs_done     = 0;
    int          quiet_cycles       = 0;
    int          chars_sent         = 0;
    int          newlines_sent      = 0;
    int          unprintable_sent   = 0;

    int mismatches;
    int outstanding;
    int bytes_checked;
    int row_advances;

    text_glyph_column_renderer DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_character  (s_character),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_is_command (m_is_command),
        .m_out_byte   (m_out_byte),
        .m_last       (m_last)
    );

    text_glyph_column_renderer_checker u_byte_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_character   (s_character),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_is_command  (m_is_command),
        .m_out_byte    (m_out_byte),
        .m_last        (m_last),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .bytes_checked (bytes_checked),
        .row_advances  (row_advances)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
            $display("tb_text_glyph_column_renderer: FAIL");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_offs_done != hold_offs_asked) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_offs_done++;
            end
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    function automatic logic [7:0] pick_character();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            return CODE_NEWLINE;
        if (r < 82)
            return 8'($urandom_range(CODE_LAST, CODE_FIRST));
        return 8'($urandom_range(255));
    endfunction

    task automatic send_character(input logic [7:0] ch);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_character <= ch;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chars_sent++;
        if (ch == CODE_NEWLINE)
            newlines_sent++;
        else if (!(ch inside {[CODE_FIRST:CODE_LAST]}))
            unprintable_sent++;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_character(pick_character());
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED[i]) send_character(DIRECTED[i]);
        wait_for_drain();

        send_random(35);
        // hold the receiver off while requests keep coming
        hold_offs_asked <= hold_offs_asked + 1;
        send_random(25);
        wait_for_drain();

        set_idling(84, 0);
        send_random(40);
        set_idling(0, 84);
        send_random(40);
        wait_for_drain();
        set_idling(19, 19);
        send_random(45);
        set_idling(0, 0);
        send_random(10);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Rendered %0d characters (%0d newlines, %0d unprintable)",
                 chars_sent, newlines_sent, unprintable_sent);
        $display("into %0d bytes with %0d row advances; idling: none, sender 84%%, %s%0d",
                 bytes_checked, row_advances, "receiver 84%, both 19%, hold-off ",
                 HOLD_OFF_CYCLES);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_text_glyph_column_renderer: PASS");
        end else begin
            $display("tb_text_glyph_column_renderer: FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/tgcr_pkg.sv
rtl/text_glyph_column_renderer.sv
rtl/tgcr_checker.sv
test/text_glyph_column_renderer_checker.sv
test/tb_text_glyph_column_renderer.sv
